// ----- hw/rtl/grp_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// grp_pkg
// Shared types and constants of the guillotine rectangle packer.
// ----------------------------------------------------------------------------
package grp_pkg;

    localparam int FREE_SLOTS = 64;
    localparam int COORD_BITS = 16;
    localparam int IDX_BITS   = $clog2(FREE_SLOTS);
    localparam int CNT_BITS   = $clog2(FREE_SLOTS + 1);
    localparam int SCORE_BITS = 2 * COORD_BITS;

    // status codes
    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_NONE = 2'd1;
    localparam logic [1:0] ST_FULL = 2'd2;

    // configuration register indexes
    localparam logic [1:0] CFG_BIN_W  = 2'd0;
    localparam logic [1:0] CFG_BIN_H  = 2'd1;
    localparam logic [1:0] CFG_CHOICE = 2'd2;
    localparam logic [1:0] CFG_SPLIT  = 2'd3;

    // split rules
    localparam logic [1:0] SPL_SHORT_LEFT = 2'd0;
    localparam logic [1:0] SPL_LONG_LEFT  = 2'd1;
    localparam logic [1:0] SPL_SHORT_AXIS = 2'd2;
    localparam logic [1:0] SPL_LONG_AXIS  = 2'd3;

    typedef struct packed {
        logic [COORD_BITS-1:0] x;
        logic [COORD_BITS-1:0] y;
        logic [COORD_BITS-1:0] w;
        logic [COORD_BITS-1:0] h;
    } rect_t;

    typedef enum logic [3:0] {
        S_INIT,
        S_IDLE,
        S_SCAN,
        S_DECIDE,
        S_SHIFT,
        S_APPEND_BOT,
        S_APPEND_RGT,
        S_DONE
    } state_t;

endpackage

// ----- hw/rtl/guillotine_rect_packer_unit.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// guillotine_rect_packer_unit
// Free-list rectangle packer; the free list lives in one synchronous RAM.
// ----------------------------------------------------------------------------
// channel  dir  word
// s_axis   in   tdata {restart_bin, commit, req_height, req_width}
// m_axis   out  tdata {free_count, rotated, placed_height, placed_width,
//                      pos_y, pos_x, status}
// cfg      in   index 0 bin_width, 1 bin_height, 2 choice_rule, 3 split_rule
//
// A request scans the free entries (one read per cycle) until an exact
// fit or the last entry, then on commit shifts the entries after the
// chosen one down by one (one move per cycle) and appends up to two
// remainders. After reset, entry zero is written as a 1024 x 1024 bin and
// the count starts at one. One request is in flight at a time; the
// result register holds a word while m_axis_tready is low, and the next
// request may run meanwhile, waiting in the done state until the word leaves.
module guillotine_rect_packer_unit
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // req_width[15:0], req_height[31:16], commit[32], restart_bin[33], zero
    input  logic [39:0]  s_axis_tdata,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // status[1:0], pos_x[17:2], pos_y[33:18], placed_width[49:34],
    // placed_height[65:50], rotated[66], free_count[73:67], zero
    output logic [79:0]  m_axis_tdata,
    input  logic         cfg_valid,
    output logic         cfg_ready,
    input  logic [1:0]   cfg_index,
    input  logic [15:0]  cfg_data
);

    localparam int CB = grp_pkg::COORD_BITS;
    localparam int IB = grp_pkg::IDX_BITS;
    localparam int NB = grp_pkg::CNT_BITS;
    localparam int SB = grp_pkg::SCORE_BITS;

    grp_pkg::state_t state_reg, state_next;

    // configuration
    logic [15:0] bin_w_reg, bin_h_reg;
    logic        choice_reg;
    logic [1:0]  split_reg;

    // request
    logic [15:0] rw_reg, rh_reg;
    logic        commit_reg;

    // list control
    logic [NB-1:0] count_reg, count_next;
    logic          restart_pend_reg, restart_pend_next;
    logic [NB-1:0] rd_idx_reg, rd_idx_next;
    logic [NB-1:0] chk_idx_reg, chk_idx_next;
    logic          rd_live_reg, rd_live_next;
    logic          found_reg, found_next;
    logic          rot_reg, rot_next;
    logic [SB-1:0] best_reg, best_next;
    logic [IB-1:0] sel_reg, sel_next;
    grp_pkg::rect_t f_reg, f_next;
    grp_pkg::rect_t bot_reg, bot_next, rgt_reg, rgt_next;
    logic          bot_ok_reg, bot_ok_next, rgt_ok_reg, rgt_ok_next;

    // result of the current request and output word
    logic [79:0]   res_reg, res_next;
    logic          out_valid_reg, out_valid_next;
    logic [79:0]   out_data_reg, out_data_next;

    // memory
    grp_pkg::rect_t mem [grp_pkg::FREE_SLOTS];
    grp_pkg::rect_t rd_data;
    logic [IB-1:0]  rd_addr;
    logic           wr_en;
    logic [IB-1:0]  wr_addr;
    grp_pkg::rect_t wr_data;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

    assign s_axis_tready = (state_reg == grp_pkg::S_IDLE);
    assign cfg_ready     = 1'b1;
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bin_w_reg  <= 16'd1024;
            bin_h_reg  <= 16'd1024;
            choice_reg <= 1'b0;
            split_reg  <= grp_pkg::SPL_SHORT_LEFT;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                grp_pkg::CFG_BIN_W:  bin_w_reg  <= cfg_data;
                grp_pkg::CFG_BIN_H:  bin_h_reg  <= cfg_data;
                grp_pkg::CFG_CHOICE: choice_reg <= cfg_data[0];
                grp_pkg::CFG_SPLIT:  split_reg  <= cfg_data[1:0];
                default: ;
            endcase
        end
    end

    // entry zero reads as the bin while a restart is pending
    grp_pkg::rect_t bin_rect, cur;
    always_comb
    begin
        bin_rect.x = '0;
        bin_rect.y = '0;
        bin_rect.w = CB'(bin_w_reg);
        bin_rect.h = CB'(bin_h_reg);
    end

    // candidate evaluation on the current entry
    logic [CB-1:0] rwc, rhc;
    logic fit_u, fit_r, ex_u, ex_r, better_u;
    logic [SB-1:0] sc_u, sc_r, best_u;
    logic [CB-1:0] du_w, du_h, dr_w, dr_h;
    always_comb
    begin
        cur = (restart_pend_reg && chk_idx_reg == '0) ? bin_rect : rd_data;
        rwc = CB'(rw_reg);
        rhc = CB'(rh_reg);
        ex_u  = ({16'd0, rw_reg} == 32'(cur.w)) && ({16'd0, rh_reg} == 32'(cur.h));
        ex_r  = ({16'd0, rh_reg} == 32'(cur.w)) && ({16'd0, rw_reg} == 32'(cur.h));
        fit_u = ({16'd0, rw_reg} <= 32'(cur.w)) && ({16'd0, rh_reg} <= 32'(cur.h));
        fit_r = ({16'd0, rh_reg} <= 32'(cur.w)) && ({16'd0, rw_reg} <= 32'(cur.h));
        du_w = cur.w - rwc;
        du_h = cur.h - rhc;
        dr_w = cur.w - rhc;
        dr_h = cur.h - rwc;
        if (choice_reg)
        begin
            sc_u = SB'((du_w < du_h) ? du_w : du_h);
            sc_r = SB'((dr_w < dr_h) ? dr_w : dr_h);
        end
        else
        begin
            // same area for both orientations when it fits
            sc_u = SB'(cur.w) * SB'(cur.h) - SB'(rwc) * SB'(rhc);
            sc_r = sc_u;
        end
        better_u = fit_u && (!found_reg || sc_u < best_reg);
        best_u   = better_u ? sc_u : best_reg;
    end

    // split geometry of the chosen entry
    logic [CB-1:0] pw, ph, lw, lh;
    logic          horiz;
    always_comb
    begin
        pw = rot_reg ? rhc : rwc;
        ph = rot_reg ? rwc : rhc;
        lw = f_reg.w - pw;
        lh = f_reg.h - ph;
        case (split_reg)
            grp_pkg::SPL_SHORT_LEFT: horiz = lw <= lh;
            grp_pkg::SPL_LONG_LEFT:  horiz = lw > lh;
            grp_pkg::SPL_SHORT_AXIS: horiz = f_reg.w <= f_reg.h;
            default:                 horiz = f_reg.w > f_reg.h;
        endcase
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            grp_pkg::S_INIT:
                state_next = grp_pkg::S_IDLE;
            grp_pkg::S_IDLE:
                if (s_axis_tvalid && s_axis_tready)
                    state_next = grp_pkg::S_SCAN;
            grp_pkg::S_SCAN:
                if (rd_live_reg && (ex_u || ex_r || chk_idx_reg + 1'b1 >= count_reg))
                    state_next = grp_pkg::S_DECIDE;
                else if (!rd_live_reg && count_reg == '0)
                    state_next = grp_pkg::S_DECIDE;
            grp_pkg::S_DECIDE:
                if (!found_reg || !commit_reg
                    || (32'(count_reg) - 1 + 32'(bot_ok_next) + 32'(rgt_ok_next)
                        > grp_pkg::FREE_SLOTS))
                    state_next = grp_pkg::S_DONE;
                else
                    state_next = grp_pkg::S_SHIFT;
            grp_pkg::S_SHIFT:
                if (!rd_live_reg && rd_idx_reg >= count_reg)
                    state_next = grp_pkg::S_APPEND_BOT;
            grp_pkg::S_APPEND_BOT:
                state_next = grp_pkg::S_APPEND_RGT;
            grp_pkg::S_APPEND_RGT:
                state_next = grp_pkg::S_DONE;
            grp_pkg::S_DONE:
                if (!out_valid_reg || m_axis_tready)
                    state_next = grp_pkg::S_IDLE;
            default:
                state_next = grp_pkg::S_IDLE;
        endcase
    end

    // datapath and memory control
    always_comb
    begin
        count_next        = count_reg;
        restart_pend_next = restart_pend_reg;
        rd_idx_next       = rd_idx_reg;
        chk_idx_next      = chk_idx_reg;
        rd_live_next      = 1'b0;
        found_next        = found_reg;
        rot_next          = rot_reg;
        best_next         = best_reg;
        sel_next          = sel_reg;
        f_next            = f_reg;
        bot_next          = bot_reg;
        rgt_next          = rgt_reg;
        bot_ok_next       = bot_ok_reg;
        rgt_ok_next       = rgt_ok_reg;
        res_next          = res_reg;
        out_valid_next    = out_valid_reg && !m_axis_tready;
        out_data_next     = out_data_reg;
        rd_addr           = rd_idx_reg[IB-1:0];
        wr_en             = 1'b0;
        wr_addr           = '0;
        wr_data           = bot_reg;

        case (state_reg)
            grp_pkg::S_INIT:
            begin
                // entry zero spans the reset bin
                wr_en     = 1'b1;
                wr_addr   = '0;
                wr_data.x = '0;
                wr_data.y = '0;
                wr_data.w = CB'(1024);
                wr_data.h = CB'(1024);
            end
            grp_pkg::S_IDLE:
            begin
                if (s_axis_tvalid && s_axis_tready)
                begin
                    if (s_axis_tdata[33])
                    begin
                        restart_pend_next = 1'b1;
                        count_next        = NB'(1);
                    end
                    found_next   = 1'b0;
                    best_next    = '0;
                    rd_idx_next  = '0;
                    chk_idx_next = '0;
                end
            end
            grp_pkg::S_SCAN:
            begin
                // issue reads one ahead of the compare
                if (!rd_live_reg)
                begin
                    if (count_reg != '0)
                    begin
                        rd_addr      = '0;
                        rd_idx_next  = NB'(1);
                        rd_live_next = 1'b1;
                    end
                end
                else
                begin
                    rd_addr      = rd_idx_reg[IB-1:0];
                    rd_idx_next  = rd_idx_reg + 1'b1;
                    rd_live_next = rd_idx_reg < count_reg;
                    chk_idx_next = chk_idx_reg + 1'b1;
                    if (ex_u || ex_r)
                    begin
                        found_next = 1'b1;
                        rot_next   = !ex_u;
                        sel_next   = chk_idx_reg[IB-1:0];
                        f_next     = cur;
                        rd_live_next = 1'b0;
                    end
                    else
                    begin
                        if (better_u)
                        begin
                            found_next = 1'b1;
                            best_next  = sc_u;
                            rot_next   = 1'b0;
                            sel_next   = chk_idx_reg[IB-1:0];
                            f_next     = cur;
                        end
                        if (fit_r && (!(found_reg || better_u) || sc_r < best_u))
                        begin
                            found_next = 1'b1;
                            best_next  = sc_r;
                            rot_next   = 1'b1;
                            sel_next   = chk_idx_reg[IB-1:0];
                            f_next     = cur;
                        end
                    end
                end
            end
            grp_pkg::S_DECIDE:
            begin
                bot_next.x = f_reg.x;
                bot_next.y = f_reg.y + ph;
                bot_next.h = lh;
                bot_next.w = horiz ? f_reg.w : pw;
                rgt_next.x = f_reg.x + pw;
                rgt_next.y = f_reg.y;
                rgt_next.w = lw;
                rgt_next.h = horiz ? ph : f_reg.h;
                bot_ok_next = (bot_next.w != '0) && (bot_next.h != '0);
                rgt_ok_next = (rgt_next.w != '0) && (rgt_next.h != '0);
                res_next = '0;
                if (!found_reg)
                begin
                    res_next[1:0] = grp_pkg::ST_NONE;
                end
                else
                begin
                    res_next[1:0]   = grp_pkg::ST_OK;
                    res_next[17:2]  = 16'(f_reg.x);
                    res_next[33:18] = 16'(f_reg.y);
                    res_next[49:34] = 16'(pw);
                    res_next[65:50] = 16'(ph);
                    res_next[66]    = rot_reg;
                    if (commit_reg && (32'(count_reg) - 1 + 32'(bot_ok_next)
                        + 32'(rgt_ok_next) > grp_pkg::FREE_SLOTS))
                        res_next[1:0] = grp_pkg::ST_FULL;
                end
                // a pending restart writes the bin into entry zero first
                if (restart_pend_reg)
                begin
                    wr_en   = 1'b1;
                    wr_addr = '0;
                    wr_data = bin_rect;
                    restart_pend_next = 1'b0;
                end
                rd_idx_next = NB'(sel_reg) + 1'b1;
                chk_idx_next = NB'(sel_reg);
            end
            grp_pkg::S_SHIFT:
            begin
                // read entry k, then write it to k - 1
                if (rd_live_reg)
                begin
                    wr_en        = 1'b1;
                    wr_addr      = chk_idx_reg[IB-1:0];
                    wr_data      = rd_data;
                    chk_idx_next = chk_idx_reg + 1'b1;
                end
                if (rd_idx_reg < count_reg)
                begin
                    rd_addr      = rd_idx_reg[IB-1:0];
                    rd_idx_next  = rd_idx_reg + 1'b1;
                    rd_live_next = 1'b1;
                end
                if (!rd_live_reg && rd_idx_reg >= count_reg)
                    count_next = count_reg - 1'b1;
            end
            grp_pkg::S_APPEND_BOT:
            begin
                if (bot_ok_reg)
                begin
                    wr_en      = 1'b1;
                    wr_addr    = count_reg[IB-1:0];
                    wr_data    = bot_reg;
                    count_next = count_reg + 1'b1;
                end
            end
            grp_pkg::S_APPEND_RGT:
            begin
                if (rgt_ok_reg)
                begin
                    wr_en      = 1'b1;
                    wr_addr    = count_reg[IB-1:0];
                    wr_data    = rgt_reg;
                    count_next = count_reg + 1'b1;
                end
            end
            grp_pkg::S_DONE:
            begin
                // load the output word once the previous one has left
                if (!out_valid_reg || m_axis_tready)
                begin
                    out_valid_next       = 1'b1;
                    out_data_next        = res_reg;
                    out_data_next[73:67] = 7'(count_reg);
                end
            end
            default: ;
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= grp_pkg::S_INIT;
            count_reg        <= NB'(1);
            restart_pend_reg <= 1'b0;
            rd_live_reg      <= 1'b0;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            count_reg        <= count_next;
            restart_pend_reg <= restart_pend_next;
            rd_live_reg      <= rd_live_next;
            out_valid_reg    <= out_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (s_axis_tvalid && s_axis_tready)
        begin
            rw_reg     <= s_axis_tdata[15:0];
            rh_reg     <= s_axis_tdata[31:16];
            commit_reg <= s_axis_tdata[32];
        end
        rd_idx_reg   <= rd_idx_next;
        chk_idx_reg  <= chk_idx_next;
        found_reg    <= found_next;
        rot_reg      <= rot_next;
        best_reg     <= best_next;
        sel_reg      <= sel_next;
        f_reg        <= f_next;
        bot_reg      <= bot_next;
        rgt_reg      <= rgt_next;
        bot_ok_reg   <= bot_ok_next;
        rgt_ok_reg   <= rgt_ok_next;
        res_reg      <= res_next;
        out_data_reg <= out_data_next;
    end

endmodule
